### hw/rtl/pnea_pkg.sv
`timescale 1ns / 1ps
package pnea_pkg;

  // Unknowns per free frame
  localparam int POSE_DOF = 6;
  localparam logic [2:0] SLOT_LAST = 3'(POSE_DOF - 1);

  // Command queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef enum logic [1:0] {
    OP_ACC     = 2'd0,
    OP_RD_MAT  = 2'd1,
    OP_RD_GRAD = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_APPLY   = 3'd1,
    CMD_RD_MAT  = 3'd2,
    CMD_RD_GRAD = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         frame_a;
    logic [3:0]         frame_b;
    logic [2:0]         pose_slot;
    logic signed [31:0] jac_a;
    logic signed [31:0] jac_b;
    logic signed [31:0] residual_value;
    logic [6:0]         read_row;
    logic [6:0]         read_col;
  } in_t;

  typedef struct packed {
    logic signed [63:0] read_value;
    logic               read_valid;
    logic               row_applied;
    logic               saturated;
  } out_t;

  // One classified request as it travels from front to back
  typedef struct packed {
    cmd_kind_t                  kind;
    logic [3:0]                 frame_a;
    logic [3:0]                 frame_b;
    logic signed [31:0]         residual;
    logic [6:0]                 read_row;
    logic [6:0]                 read_col;
    logic [POSE_DOF-1:0][31:0]  buf_a;
    logic [POSE_DOF-1:0][31:0]  buf_b;
  } cmd_t;

endpackage

### hw/rtl/pnea_ram.sv
`timescale 1ns / 1ps
module pnea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/pnea_front.sv
`timescale 1ns / 1ps
module pnea_front import pnea_pkg::*; #(
  parameter int MAX_FRAMES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  in_t  req,
  output logic push,
  output cmd_t push_data
);

  localparam int UNK = (MAX_FRAMES - 1) * POSE_DOF;

  logic [POSE_DOF-1:0][31:0] buf_a_r, buf_b_r;
  logic [POSE_DOF-1:0][31:0] snap_a, snap_b;
  logic                      slot_ok;
  logic                      row_ok, col_ok;

  assign slot_ok = (32'(req.pose_slot) < POSE_DOF);
  assign row_ok  = (32'(req.read_row) < UNK);
  assign col_ok  = (32'(req.read_col) < UNK);

  // Row buffer with this request's slot merged in
  always_comb begin
    snap_a = buf_a_r;
    snap_b = buf_b_r;
    if (req.op == OP_ACC && slot_ok) begin
      snap_a[req.pose_slot] = req.jac_a;
      snap_b[req.pose_slot] = req.jac_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_a_r <= '0;
      buf_b_r <= '0;
    end else if (accept && req.op == OP_ACC && slot_ok) begin
      buf_a_r <= snap_a;
      buf_b_r <= snap_b;
    end
  end

  // Classify the request
  always_comb begin
    push_data.frame_a  = req.frame_a;
    push_data.frame_b  = req.frame_b;
    push_data.residual = req.residual_value;
    push_data.read_row = req.read_row;
    push_data.read_col = req.read_col;
    push_data.buf_a    = snap_a;
    push_data.buf_b    = snap_b;
    case (req.op)
      OP_ACC:     push_data.kind = (req.pose_slot == SLOT_LAST) ? CMD_APPLY : CMD_NONE;
      OP_RD_MAT:  push_data.kind = (row_ok && col_ok) ? CMD_RD_MAT : CMD_NONE;
      OP_RD_GRAD: push_data.kind = row_ok ? CMD_RD_GRAD : CMD_NONE;
      OP_CLEAR:   push_data.kind = CMD_CLEAR;
      default:    push_data.kind = CMD_NONE;
    endcase
  end

  assign push = accept;

endmodule

### hw/rtl/pnea_fifo.sv
`timescale 1ns / 1ps
module pnea_fifo import pnea_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  assign head  = mem_r[rptr_r];
  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);

endmodule

### hw/rtl/pnea_back.sv
`timescale 1ns / 1ps
module pnea_back import pnea_pkg::*; #(
  parameter int MAX_FRAMES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t q_head,
  output logic q_pop,
  output logic init,
  output logic out_strobe,
  output out_t out_data
);

  localparam int UNK   = (MAX_FRAMES - 1) * POSE_DOF;
  localparam int MAT_D = UNK * UNK;
  localparam int UIW   = $clog2(UNK);
  localparam int MAW   = $clog2(MAT_D);
  localparam int GAW   = $clog2(UNK);
  localparam logic [2:0] SL = 3'(POSE_DOF - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_READ  = 5'b00100,
    S_UPD   = 5'b01000,
    S_CLR   = 5'b10000
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [2:0]         i_r, j_r, k_r;
  logic               gph_r;
  logic [MAW-1:0]     addr_r, clr_cnt_r;
  logic               gsel_r, clip_r, clr_emit_r, init_r;
  logic signed [63:0] prod_r;
  out_t               out_r;
  logic               strobe_r;

  // Term selection
  logic               va, vb, diff, en;
  logic [UIW-1:0]     ba, bb, row, col;
  logic signed [31:0] op1, op2, ai, aj, bi, bj;
  logic               is_grad;

  // Sequencer advance
  logic [2:0]         ni, nj, nk;
  logic               ng, last;

  // Memory and update
  logic [63:0]        mat_rdata, grad_rdata;
  logic signed [63:0] old_v, sum_v;
  logic signed [64:0] wide_sum;
  logic               ovf;
  logic               mat_we, grad_we, rd_en;
  logic [MAW-1:0]     mat_waddr;
  logic [GAW-1:0]     grad_waddr;
  logic [63:0]        mat_wdata, grad_wdata;

  assign va   = (cmd_r.frame_a != 4'd0) && (32'(cmd_r.frame_a) < MAX_FRAMES);
  assign vb   = (cmd_r.frame_b != 4'd0) && (32'(cmd_r.frame_b) < MAX_FRAMES);
  assign ba   = va ? UIW'((32'(cmd_r.frame_a) - 1) * POSE_DOF) : '0;
  assign bb   = vb ? UIW'((32'(cmd_r.frame_b) - 1) * POSE_DOF) : '0;
  assign diff = (i_r != j_r);
  assign ai   = $signed(cmd_r.buf_a[i_r]);
  assign aj   = $signed(cmd_r.buf_a[j_r]);
  assign bi   = $signed(cmd_r.buf_b[i_r]);
  assign bj   = $signed(cmd_r.buf_b[j_r]);

  // Which add comes next in the row: diagonal, mirror, cross, then gradient
  always_comb begin
    en      = 1'b0;
    row     = '0;
    col     = '0;
    op1     = ai;
    op2     = aj;
    is_grad = 1'b0;
    case ({gph_r, k_r})
      4'd0: begin en = va; row = ba + UIW'(i_r); col = ba + UIW'(j_r); end
      4'd1: begin en = va & diff; row = ba + UIW'(j_r); col = ba + UIW'(i_r); end
      4'd2: begin
        en = vb; row = bb + UIW'(i_r); col = bb + UIW'(j_r); op1 = bi; op2 = bj;
      end
      4'd3: begin
        en = vb & diff; row = bb + UIW'(j_r); col = bb + UIW'(i_r); op1 = bi; op2 = bj;
      end
      4'd4: begin
        en = va & vb; row = ba + UIW'(i_r); col = bb + UIW'(j_r); op1 = ai; op2 = bj;
      end
      4'd5: begin
        en = va & vb; row = bb + UIW'(j_r); col = ba + UIW'(i_r); op1 = ai; op2 = bj;
      end
      4'd6: begin
        en = va & vb & diff; row = ba + UIW'(j_r); col = bb + UIW'(i_r); op1 = aj; op2 = bi;
      end
      4'd7: begin
        en = va & vb & diff; row = bb + UIW'(i_r); col = ba + UIW'(j_r); op1 = aj; op2 = bi;
      end
      4'd8: begin
        en = va; row = ba + UIW'(i_r); op1 = ai; op2 = cmd_r.residual; is_grad = 1'b1;
      end
      4'd9: begin
        en = vb; row = bb + UIW'(i_r); op1 = bi; op2 = cmd_r.residual; is_grad = 1'b1;
      end
      default: en = 1'b0;
    endcase
  end

  // Step i, j >= i, term k; two gradient terms close each i
  always_comb begin
    ni   = i_r;
    nj   = j_r;
    nk   = k_r;
    ng   = gph_r;
    last = 1'b0;
    if (!gph_r) begin
      if (k_r != 3'd7) begin
        nk = k_r + 3'd1;
      end else begin
        nk = 3'd0;
        if (j_r != SL) begin
          nj = j_r + 3'd1;
        end else begin
          ng = 1'b1;
        end
      end
    end else if (k_r == 3'd0) begin
      nk = 3'd1;
    end else begin
      nk = 3'd0;
      ng = 1'b0;
      if (i_r != SL) begin
        ni = i_r + 3'd1;
        nj = i_r + 3'd1;
      end else begin
        last = 1'b1;
      end
    end
  end

  // Saturating add of the product onto the stored entry
  assign old_v    = gsel_r ? $signed(grad_rdata) : $signed(mat_rdata);
  assign wide_sum = {old_v[63], old_v} + {prod_r[63], prod_r};
  assign ovf      = (wide_sum[64] != wide_sum[63]);
  assign sum_v    = ovf ? (wide_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                        : wide_sum[63:0];

  // Memory ports
  assign rd_en      = (state_r == S_READ);
  assign mat_we     = (state_r == S_CLR) ||
                      (state_r == S_UPD && cmd_r.kind == CMD_APPLY && !gsel_r);
  assign mat_waddr  = (state_r == S_CLR) ? clr_cnt_r : addr_r;
  assign mat_wdata  = (state_r == S_CLR) ? 64'd0 : sum_v;
  assign grad_we    = (state_r == S_CLR && 32'(clr_cnt_r) < UNK) ||
                      (state_r == S_UPD && cmd_r.kind == CMD_APPLY && gsel_r);
  assign grad_waddr = (state_r == S_CLR) ? clr_cnt_r[GAW-1:0] : addr_r[GAW-1:0];
  assign grad_wdata = (state_r == S_CLR) ? 64'd0 : sum_v;

  pnea_ram #(.WIDTH(64), .DEPTH(MAT_D)) u_mat (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (mat_rdata)
  );

  pnea_ram #(.WIDTH(64), .DEPTH(UNK)) u_grad (
    .clk   (clk),
    .we    (grad_we),
    .waddr (grad_waddr),
    .wdata (grad_wdata),
    .re    (rd_en),
    .raddr (addr_r[GAW-1:0]),
    .rdata (grad_rdata)
  );

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_cnt_r  <= '0;
      clr_emit_r <= 1'b0;
      init_r     <= 1'b1;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_head;
            i_r     <= '0;
            j_r     <= '0;
            k_r     <= '0;
            gph_r   <= 1'b0;
            clip_r  <= 1'b0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          case (cmd_r.kind)
            CMD_RD_MAT: begin
              addr_r  <= MAW'(cmd_r.read_row) * MAW'(UNK) + MAW'(cmd_r.read_col);
              state_r <= S_READ;
            end
            CMD_RD_GRAD: begin
              addr_r  <= MAW'(cmd_r.read_row);
              state_r <= S_READ;
            end
            CMD_CLEAR: begin
              clr_cnt_r  <= '0;
              clr_emit_r <= 1'b1;
              state_r    <= S_CLR;
            end
            CMD_APPLY: begin
              if (en) begin
                addr_r  <= is_grad ? MAW'(row) : MAW'(row) * MAW'(UNK) + MAW'(col);
                gsel_r  <= is_grad;
                prod_r  <= op1 * op2;
                state_r <= S_READ;
              end else begin
                i_r   <= ni;
                j_r   <= nj;
                k_r   <= nk;
                gph_r <= ng;
                if (last) begin
                  out_r    <= '{read_value: '0, read_valid: 1'b0,
                                row_applied: 1'b1, saturated: clip_r};
                  strobe_r <= 1'b1;
                  state_r  <= S_IDLE;
                end
              end
            end
            default: begin
              out_r    <= '0;
              strobe_r <= 1'b1;
              state_r  <= S_IDLE;
            end
          endcase
        end
        S_READ: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          case (cmd_r.kind)
            CMD_RD_MAT: begin
              out_r    <= '{read_value: $signed(mat_rdata), read_valid: 1'b1,
                            row_applied: 1'b0, saturated: 1'b0};
              strobe_r <= 1'b1;
              state_r  <= S_IDLE;
            end
            CMD_RD_GRAD: begin
              out_r    <= '{read_value: $signed(grad_rdata), read_valid: 1'b1,
                            row_applied: 1'b0, saturated: 1'b0};
              strobe_r <= 1'b1;
              state_r  <= S_IDLE;
            end
            default: begin
              clip_r <= clip_r | ovf;
              i_r    <= ni;
              j_r    <= nj;
              k_r    <= nk;
              gph_r  <= ng;
              if (last) begin
                out_r    <= '{read_value: '0, read_valid: 1'b0,
                              row_applied: 1'b1, saturated: clip_r | ovf};
                strobe_r <= 1'b1;
                state_r  <= S_IDLE;
              end else begin
                state_r <= S_ISSUE;
              end
            end
          endcase
        end
        S_CLR: begin
          if (32'(clr_cnt_r) == MAT_D - 1) begin
            init_r <= 1'b0;
            if (clr_emit_r) begin
              out_r    <= '0;
              strobe_r <= 1'b1;
            end
            clr_emit_r <= 1'b0;
            state_r    <= S_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign init       = init_r;
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

### hw/rtl/pose_normal_equation_accumulator_top.sv
`timescale 1ns / 1ps
// Every accepted request gives one result; the slot 5 request runs 156 read-modify-write
// adds (both frames valid) and also steps over the 24 skipped terms before its result
// comes.
// Clear zeroes all (MAX_FRAMES-1)^2*36 matrix entries (8100 at the default), one matrix
// entry per cycle.
// Reset: synchronous, active low; afterwards busy stays high for the same zeroing pass.
// Results are one-cycle strobes; the receiver cannot stall.
module pose_normal_equation_accumulator_top import pnea_pkg::*; #(
  parameter int MAX_FRAMES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_strobe,
  output out_t out_data
);

  logic accept, push, pop, full, empty, init;
  cmd_t push_data, head;

  assign accept = start && !busy;
  assign busy   = full || init;

  pnea_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req       (in_data),
    .push      (push),
    .push_data (push_data)
  );

  pnea_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  pnea_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_head     (head),
    .q_pop      (pop),
    .init       (init),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

### hw/rtl/pnea_checker.sv
`timescale 1ns / 1ps
module pnea_checker import pnea_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_strobe,
  input out_t out_data
);

  // Results never come in two adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  // A read result never reports an applied row
  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.read_valid |-> !out_data.row_applied && !out_data.saturated)
    else $error("read result with apply flags");

  // Clipping only on an applied row
  a_sat_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.saturated |-> out_data.row_applied)
    else $error("saturation without applied row");

  // Zeroing pass holds off requests right after reset
  a_init_busy: assert property (@(posedge clk)
    $rose(rst_n) |-> busy)
    else $error("not busy after reset");

endmodule

bind pose_normal_equation_accumulator_top pnea_checker u_pnea_checker (.*);
